// ===== hw/rtl/dwabbr_pkg.sv =====
// Shared types, constants and the LEB128 step function for the abbreviation table parser.
// No dependencies; every other file in hw/rtl imports this package.
package dwabbr_pkg;

   localparam int MAX_ENTRIES         = 256;
   localparam int MAX_ATTRS_TOTAL     = 2048;
   localparam int MAX_ATTRS_PER_ENTRY = 32;

   localparam int ENTRY_IDX_W = $clog2(MAX_ENTRIES);
   localparam int ENTRY_CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int ATTR_IDX_W  = $clog2(MAX_ATTRS_TOTAL);
   localparam int ATTR_CNT_W  = $clog2(MAX_ATTRS_TOTAL + 1);
   localparam int PER_CNT_W   = $clog2(MAX_ATTRS_PER_ENTRY + 1);

   localparam logic [1:0] FUNC_BYTE   = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [2:0] KIND_ENTRY_DONE = 3'd0;
   localparam logic [2:0] KIND_TABLE_DONE = 3'd1;
   localparam logic [2:0] KIND_ATTR       = 3'd2;
   localparam logic [2:0] KIND_MISS       = 3'd3;
   localparam logic [2:0] KIND_LEB_OVF    = 3'd4;
   localparam logic [2:0] KIND_FULL       = 3'd5;
   localparam logic [2:0] KIND_TRUNC      = 3'd6;

   localparam logic [15:0] FORM_IMPLICIT_CONST = 16'h0021;
   localparam logic [7:0]  CHILDREN_YES        = 8'h01;

   localparam logic [6:0] LEB_W_CODE   = 7'd32;
   localparam logic [6:0] LEB_W_NARROW = 7'd16;
   localparam logic [6:0] LEB_W_WIDE   = 7'd64;

   typedef enum logic [1:0] {
      LEB_MORE,
      LEB_DONE,
      LEB_OVF
   } leb_stat_type;

   typedef struct packed {
      leb_stat_type stat;
      logic [63:0]  acc;
      logic [6:0]   shift;
   } leb_res_type;

   typedef struct packed {
      logic [15:0]           tag;
      logic                  children;
      logic [PER_CNT_W-1:0]  count;
      logic [ATTR_CNT_W-1:0] first;
   } info_type;

   typedef struct packed {
      logic                   en;
      logic [ENTRY_IDX_W-1:0] addr;
      logic [31:0]            code;
      info_type               info;
   } entry_wr_type;

   typedef struct packed {
      logic                  en;
      logic [ATTR_IDX_W-1:0] addr;
      logic [31:0]           pair;
      logic [63:0]           cval;
   } attr_wr_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        entry_code;
      logic [15:0]        tag;
      logic               has_children;
      logic [5:0]         pair_count;
      logic               attr_valid;
      logic [15:0]        attr_name;
      logic [15:0]        attr_form;
      logic signed [63:0] implicit_value;
      logic [8:0]         entry_total;
      logic               last;
   } rsp_type;

   // One LEB128 byte: accumulate payload, check range, sign-extend at the end.
   function automatic leb_res_type leb_feed(logic [7:0] b, logic [6:0] sh,
                                            logic [63:0] acc_in, logic [6:0] width,
                                            logic sgn);
      leb_res_type r;
      logic [63:0] pl;
      logic [63:0] acc;
      logic        ovf;
      pl    = {57'd0, b[6:0]};
      acc   = (sh == 7'd0) ? 64'd0 : acc_in;
      ovf   = 1'b0;
      r.stat  = LEB_MORE;
      r.shift = 7'd0;
      if (sh >= 7'd63) begin
         if (b[7]) begin
            ovf = 1'b1;
         end else if (sgn) begin
            ovf = (b[6:0] != 7'h00) && (b[6:0] != 7'h7f);
         end else if ((b[6:0] > 7'd1) || (width < LEB_W_WIDE)) begin
            ovf = (b[6:0] != 7'h00);
         end
         acc[63] = acc[63] | b[0];
         r.stat  = ovf ? LEB_OVF : LEB_DONE;
      end else begin
         if (!sgn) begin
            if (sh >= width) begin
               ovf = (pl != 64'd0);
            end else begin
               ovf = (((pl << sh) >> width) != 64'd0);
            end
         end
         if (ovf) begin
            r.stat = LEB_OVF;
         end else begin
            acc = acc | (pl << sh);
            if (b[7]) begin
               r.stat  = LEB_MORE;
               r.shift = sh + 7'd7;
            end else begin
               if (sgn && b[6] && (({1'b0, sh} + 8'd7) < 8'd64)) begin
                  acc = acc | ({64{1'b1}} << (sh + 7'd7));
               end
               r.stat = LEB_DONE;
            end
         end
      end
      r.acc = acc;
      return r;
   endfunction

endpackage

// ===== hw/rtl/debug_abbrev_table_parser.sv =====
// Top level of the abbreviation table parser: request decode, lookup walk, response register.
// Depends on dwabbr_pkg, dwabbr_parser and dwabbr_store.
//
//  channel | ports          | direction | moves
//  --------+----------------+-----------+----------------------------------------
//  req     | req_valid/stall| in        | section byte, lookup or clear request
//  rsp     | rsp_valid/stall| out       | entry, table, attribute, miss or error
//
// A section byte or a clear is taken while idle; a byte with one or two results then holds
// req_stall until each result is in the response register. A lookup reads the entry memory
// for each entry scanned (read, compare) up to the first match, then checks the hit and reads
// and emits each attribute from the attribute memory; a miss is emitted after the scan.
// Reset is synchronous and clears the parse state; memories are not cleared. rsp_stall
// holds the response register and the walk behind it.
module debug_abbrev_table_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_section,
   input  logic [31:0]        req_lookup_code,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [31:0]        rsp_entry_code,
   output logic [15:0]        rsp_tag,
   output logic               rsp_has_children,
   output logic [5:0]         rsp_pair_count,
   output logic               rsp_attr_valid,
   output logic [15:0]        rsp_attr_name,
   output logic [15:0]        rsp_attr_form,
   output logic signed [63:0] rsp_implicit_value,
   output logic [8:0]         rsp_entry_total,
   output logic               rsp_last
);
   import dwabbr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_EMIT, S_LK_RD, S_LK_CMP, S_LK_HIT, S_LK_ARD, S_LK_AOUT, S_MISS
   } state_type;

   state_type              state_ff;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                pend0_ff, pend1_ff;
   logic                   pend_two_ff;
   logic [ENTRY_CNT_W-1:0] idx_ff;
   logic [PER_CNT_W-1:0]   aidx_ff;
   logic [31:0]            key_ff;

   logic                   accept;
   logic                   out_free;
   rsp_type                res0, res1;
   logic [1:0]             res_cnt;
   entry_wr_type           entry_wr;
   attr_wr_type            attr_wr;
   logic [ENTRY_CNT_W-1:0] entries;
   logic [31:0]            code_rd, pair_rd;
   logic [63:0]            cval_rd;
   info_type               info_rd;
   logic [ATTR_CNT_W-1:0]  attr_addr;
   rsp_type                ent_res, attr_res, miss_res;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   dwabbr_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (accept && req_func == FUNC_BYTE),
      .clear          (accept && req_func == FUNC_CLEAR),
      .data_byte      (req_data_byte),
      .end_of_section (req_end_of_section),
      .res0           (res0),
      .res1           (res1),
      .res_cnt        (res_cnt),
      .entry_wr       (entry_wr),
      .attr_wr        (attr_wr),
      .entries_stored (entries)
   );

   assign attr_addr = info_rd.first + ATTR_CNT_W'(aidx_ff);

   dwabbr_store u_store (
      .clock       (clock),
      .entry_wr    (entry_wr),
      .attr_wr     (attr_wr),
      .entry_raddr (idx_ff[ENTRY_IDX_W-1:0]),
      .attr_raddr  (attr_addr[ATTR_IDX_W-1:0]),
      .code_rd     (code_rd),
      .info_rd     (info_rd),
      .pair_rd     (pair_rd),
      .cval_rd     (cval_rd)
   );

   always_comb begin
      ent_res              = '0;
      ent_res.kind         = KIND_ATTR;
      ent_res.entry_code   = key_ff;
      ent_res.tag          = info_rd.tag;
      ent_res.has_children = info_rd.children;
      ent_res.pair_count   = 6'(info_rd.count);
      ent_res.last         = 1'b1;

      attr_res                = ent_res;
      attr_res.attr_valid     = 1'b1;
      attr_res.attr_name      = pair_rd[31:16];
      attr_res.attr_form      = pair_rd[15:0];
      attr_res.implicit_value = cval_rd;
      attr_res.last           = (aidx_ff + 1'b1 == info_rd.count);

      miss_res            = '0;
      miss_res.kind       = KIND_MISS;
      miss_res.entry_code = key_ff;
      miss_res.last       = 1'b1;
   end

   // hold a stalled response, load a new one where the walk emits
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_EMIT, S_LK_AOUT, S_MISS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         S_LK_HIT: begin
            if (out_free && info_rd.count == '0) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  key_ff      <= req_lookup_code;
                  idx_ff      <= '0;
                  pend0_ff    <= res0;
                  pend1_ff    <= res1;
                  pend_two_ff <= (res_cnt == 2'd2);
                  if (req_func == FUNC_LOOKUP) begin
                     state_ff <= (entries == '0) ? S_MISS : S_LK_RD;
                  end else if (req_func == FUNC_BYTE && res_cnt != 2'd0) begin
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_ff       <= pend0_ff;
                  pend0_ff     <= pend1_ff;
                  pend_two_ff  <= 1'b0;
                  if (!pend_two_ff) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_LK_RD: state_ff <= S_LK_CMP;
            S_LK_CMP: begin
               if (code_rd == key_ff) begin
                  state_ff <= S_LK_HIT;
               end else begin
                  // advance to the next stored entry, or give up
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= (idx_ff + 1'b1 >= entries) ? S_MISS : S_LK_RD;
               end
            end
            S_LK_HIT: begin
               aidx_ff <= '0;
               if (info_rd.count != '0) begin
                  state_ff <= S_LK_ARD;
               end else if (out_free) begin
                  rsp_ff       <= ent_res;
                  state_ff     <= S_IDLE;
               end
            end
            S_LK_ARD: state_ff <= S_LK_AOUT;
            S_LK_AOUT: begin
               if (out_free) begin
                  rsp_ff       <= attr_res;
                  aidx_ff      <= aidx_ff + 1'b1;
                  state_ff     <= attr_res.last ? S_IDLE : S_LK_ARD;
               end
            end
            S_MISS: begin
               if (out_free) begin
                  rsp_ff       <= miss_res;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_entry_code     = rsp_ff.entry_code;
   assign rsp_tag            = rsp_ff.tag;
   assign rsp_has_children   = rsp_ff.has_children;
   assign rsp_pair_count     = rsp_ff.pair_count;
   assign rsp_attr_valid     = rsp_ff.attr_valid;
   assign rsp_attr_name      = rsp_ff.attr_name;
   assign rsp_attr_form      = rsp_ff.attr_form;
   assign rsp_implicit_value = rsp_ff.implicit_value;
   assign rsp_entry_total    = rsp_ff.entry_total;
   assign rsp_last           = rsp_ff.last;

endmodule

// ===== hw/rtl/dwabbr_store.sv =====
// Entry and attribute memories of the abbreviation table, one write and one read port each.
// Depends on dwabbr_pkg; read data is registered.
module dwabbr_store (
   input  logic                               clock,
   input  dwabbr_pkg::entry_wr_type           entry_wr,
   input  dwabbr_pkg::attr_wr_type            attr_wr,
   input  logic [dwabbr_pkg::ENTRY_IDX_W-1:0] entry_raddr,
   input  logic [dwabbr_pkg::ATTR_IDX_W-1:0]  attr_raddr,
   output logic [31:0]                        code_rd,
   output dwabbr_pkg::info_type               info_rd,
   output logic [31:0]                        pair_rd,
   output logic [63:0]                        cval_rd
);
   import dwabbr_pkg::*;

   logic [31:0] code_mem [MAX_ENTRIES];
   info_type    info_mem [MAX_ENTRIES];
   logic [31:0] pair_mem [MAX_ATTRS_TOTAL];
   logic [63:0] cval_mem [MAX_ATTRS_TOTAL];

   always_ff @(posedge clock) begin
      if (entry_wr.en) begin
         code_mem[entry_wr.addr] <= entry_wr.code;
         info_mem[entry_wr.addr] <= entry_wr.info;
      end
      code_rd <= code_mem[entry_raddr];
      info_rd <= info_mem[entry_raddr];
   end

   always_ff @(posedge clock) begin
      if (attr_wr.en) begin
         pair_mem[attr_wr.addr] <= attr_wr.pair;
         cval_mem[attr_wr.addr] <= attr_wr.cval;
      end
      pair_rd <= pair_mem[attr_raddr];
      cval_rd <= cval_mem[attr_raddr];
   end

endmodule

// ===== hw/rtl/dwabbr_parser.sv =====
// Byte-at-a-time parser of the abbreviation section: LEB decode, entry and pair commit.
// Depends on dwabbr_pkg; drives the write ports of dwabbr_store and up to two results per byte.
module dwabbr_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic                               clear,
   input  logic [7:0]                         data_byte,
   input  logic                               end_of_section,
   output dwabbr_pkg::rsp_type                res0,
   output dwabbr_pkg::rsp_type                res1,
   output logic [1:0]                         res_cnt,
   output dwabbr_pkg::entry_wr_type           entry_wr,
   output dwabbr_pkg::attr_wr_type            attr_wr,
   output logic [dwabbr_pkg::ENTRY_CNT_W-1:0] entries_stored
);
   import dwabbr_pkg::*;

   typedef enum logic [2:0] {
      PH_CODE, PH_TAG, PH_CHILD, PH_NAME, PH_FORM, PH_CONST, PH_DONE, PH_HALT
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [63:0]           acc_ff, acc_in;
   logic [6:0]            shift_ff, shift_in;
   logic [31:0]           code_ff, code_in;
   logic [15:0]           tag_ff, tag_in;
   logic                  child_ff, child_in;
   logic [PER_CNT_W-1:0]  count_ff, count_in;
   logic [15:0]           name_ff, name_in;
   logic [15:0]           form_ff, form_in;
   logic [ENTRY_CNT_W-1:0] entries_ff, entries_in;
   logic [ATTR_CNT_W-1:0] attrs_ff, attrs_in;

   leb_res_type lr;
   logic [6:0]  lw;
   logic        lsgn;
   logic        halted;
   logic        commit;
   logic [63:0] commit_val;
   rsp_type     r0, r1, hres;
   logic [1:0]  cnt;

   always_comb begin
      lw   = LEB_W_NARROW;
      lsgn = 1'b0;
      case (phase_ff)
         PH_CODE:  lw = LEB_W_CODE;
         PH_CONST: begin
            lw   = LEB_W_WIDE;
            lsgn = 1'b1;
         end
         default:  lw = LEB_W_NARROW;
      endcase
      lr = leb_feed(data_byte, shift_ff, acc_ff, lw, lsgn);
   end

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      shift_in   = shift_ff;
      code_in    = code_ff;
      tag_in     = tag_ff;
      child_in   = child_ff;
      count_in   = count_ff;
      name_in    = name_ff;
      form_in    = form_ff;
      entries_in = entries_ff;
      attrs_in   = attrs_ff;
      halted     = 1'b0;
      commit     = 1'b0;
      commit_val = 64'd0;
      r0         = '0;
      r1         = '0;
      hres       = '0;
      cnt        = 2'd0;
      entry_wr   = '0;
      attr_wr    = '0;

      if (clear) begin
         phase_in   = PH_CODE;
         acc_in     = 64'd0;
         shift_in   = 7'd0;
         code_in    = 32'd0;
         tag_in     = 16'd0;
         child_in   = 1'b0;
         count_in   = '0;
         name_in    = 16'd0;
         form_in    = 16'd0;
         entries_in = '0;
         attrs_in   = '0;
      end else if (step && phase_ff != PH_DONE && phase_ff != PH_HALT) begin
         if (phase_ff != PH_CHILD && !(phase_ff == PH_CODE && shift_ff == 7'd0
                                        && data_byte == 8'h00)) begin
            acc_in   = lr.acc;
            shift_in = lr.shift;
         end
         case (phase_ff)
            PH_CODE: begin
               if (shift_ff == 7'd0 && data_byte == 8'h00) begin
                  r0.kind        = KIND_TABLE_DONE;
                  r0.entry_total = 9'(entries_ff);
                  cnt            = 2'd1;
                  phase_in       = PH_DONE;
               end else if (lr.stat == LEB_OVF) begin
                  halted    = 1'b1;
                  hres.kind = KIND_LEB_OVF;
               end else if (lr.stat == LEB_DONE) begin
                  if (entries_ff >= ENTRY_CNT_W'(MAX_ENTRIES)) begin
                     halted    = 1'b1;
                     hres.kind = KIND_FULL;
                  end else begin
                     code_in  = lr.acc[31:0];
                     phase_in = PH_TAG;
                  end
               end
            end
            PH_TAG: begin
               if (lr.stat == LEB_OVF) begin
                  halted    = 1'b1;
                  hres.kind = KIND_LEB_OVF;
               end else if (lr.stat == LEB_DONE) begin
                  tag_in   = lr.acc[15:0];
                  phase_in = PH_CHILD;
               end
            end
            PH_CHILD: begin
               child_in = (data_byte == CHILDREN_YES);
               count_in = '0;
               phase_in = PH_NAME;
            end
            PH_NAME: begin
               if (lr.stat == LEB_OVF) begin
                  halted    = 1'b1;
                  hres.kind = KIND_LEB_OVF;
               end else if (lr.stat == LEB_DONE) begin
                  name_in  = lr.acc[15:0];
                  phase_in = PH_FORM;
               end
            end
            PH_FORM: begin
               if (lr.stat == LEB_OVF) begin
                  halted    = 1'b1;
                  hres.kind = KIND_LEB_OVF;
               end else if (lr.stat == LEB_DONE) begin
                  form_in = lr.acc[15:0];
                  if (lr.acc[15:0] == FORM_IMPLICIT_CONST) begin
                     phase_in = PH_CONST;
                  end else if (name_ff == 16'd0 && lr.acc[15:0] == 16'd0) begin
                     entry_wr.en             = 1'b1;
                     entry_wr.addr           = entries_ff[ENTRY_IDX_W-1:0];
                     entry_wr.code           = code_ff;
                     entry_wr.info.tag       = tag_ff;
                     entry_wr.info.children  = child_ff;
                     entry_wr.info.count     = count_ff;
                     entry_wr.info.first     = attrs_ff - ATTR_CNT_W'(count_ff);
                     entries_in              = entries_ff + 1'b1;
                     r0.kind                 = KIND_ENTRY_DONE;
                     r0.entry_code           = code_ff;
                     r0.tag                  = tag_ff;
                     r0.has_children         = child_ff;
                     r0.pair_count           = 6'(count_ff);
                     r0.entry_total          = 9'(entries_in);
                     cnt                     = 2'd1;
                     phase_in                = PH_CODE;
                  end else begin
                     commit = 1'b1;
                  end
               end
            end
            PH_CONST: begin
               if (lr.stat == LEB_OVF) begin
                  halted    = 1'b1;
                  hres.kind = KIND_LEB_OVF;
               end else if (lr.stat == LEB_DONE) begin
                  commit     = 1'b1;
                  commit_val = lr.acc;
               end
            end
            default: begin
            end
         endcase

         if (commit) begin
            if (count_ff >= PER_CNT_W'(MAX_ATTRS_PER_ENTRY)
                || attrs_ff >= ATTR_CNT_W'(MAX_ATTRS_TOTAL)) begin
               halted    = 1'b1;
               hres.kind = KIND_FULL;
            end else begin
               attr_wr.en   = 1'b1;
               attr_wr.addr = attrs_ff[ATTR_IDX_W-1:0];
               attr_wr.pair = {name_ff, form_in};
               attr_wr.cval = commit_val;
               attrs_in     = attrs_ff + 1'b1;
               count_in     = count_ff + 1'b1;
               phase_in     = PH_NAME;
            end
         end

         if (halted) begin
            hres.entry_total = 9'(entries_ff);
            r0               = hres;
            cnt              = 2'd1;
            phase_in         = PH_HALT;
         end else if (end_of_section && phase_in != PH_DONE) begin
            // truncation follows any entry report from this byte
            hres.kind        = KIND_TRUNC;
            hres.entry_total = 9'(entries_in);
            if (cnt == 2'd1) begin
               r1 = hres;
            end else begin
               r0 = hres;
            end
            cnt      = cnt + 2'd1;
            phase_in = PH_HALT;
         end
      end
      res0    = r0;
      res1    = r1;
      res_cnt = cnt;
   end

   assign entries_stored = entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CODE;
         acc_ff     <= 64'd0;
         shift_ff   <= 7'd0;
         code_ff    <= 32'd0;
         tag_ff     <= 16'd0;
         child_ff   <= 1'b0;
         count_ff   <= '0;
         name_ff    <= 16'd0;
         form_ff    <= 16'd0;
         entries_ff <= '0;
         attrs_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         shift_ff   <= shift_in;
         code_ff    <= code_in;
         tag_ff     <= tag_in;
         child_ff   <= child_in;
         count_ff   <= count_in;
         name_ff    <= name_in;
         form_ff    <= form_in;
         entries_ff <= entries_in;
         attrs_ff   <= attrs_in;
      end
   end

endmodule

// ===== hw/rtl/dwabbr_checker.sv =====
// Port-level checks of the abbreviation table parser, bound to the top level.
// Depends on dwabbr_pkg for the request function and response kind codes.
module dwabbr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_func,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_kind,
   input logic        rsp_attr_valid,
   input logic        rsp_last
);
   import dwabbr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == FUNC_LOOKUP |=> req_stall)
      else $error("lookup request did not hold off the next request");

   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_MISS |-> rsp_last)
      else $error("lookup miss not marked last");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ATTR && !rsp_attr_valid |-> rsp_last)
      else $error("empty lookup hit not marked last");

endmodule

bind debug_abbrev_table_parser dwabbr_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_func       (req_func),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_attr_valid (rsp_attr_valid),
   .rsp_last       (rsp_last)
);
